// ===== src/vpus_pkg.sv =====
// Package for the vehicle power-up sequencer.
// Holds the state encoding, status codes, register map and configuration type.
// No dependencies.
package vpus_pkg;

    typedef enum logic [8:0] {
        ST_INIT        = 9'b000000001,
        ST_HV_START    = 9'b000000010,
        ST_READY_WAIT  = 9'b000000100,
        ST_MOTOR_START = 9'b000001000,
        ST_AWAIT_BRAKE = 9'b000010000,
        ST_RUNNING     = 9'b000100000,
        ST_SHUTDOWN    = 9'b001000000,
        ST_HV_ERROR    = 9'b010000000,
        ST_FATAL       = 9'b100000000
    } mode_t;

    localparam logic [3:0] MODE_INIT        = 4'd0;
    localparam logic [3:0] MODE_HV_START    = 4'd1;
    localparam logic [3:0] MODE_READY_WAIT  = 4'd2;
    localparam logic [3:0] MODE_MOTOR_START = 4'd3;
    localparam logic [3:0] MODE_AWAIT_BRAKE = 4'd4;
    localparam logic [3:0] MODE_RUNNING     = 4'd5;
    localparam logic [3:0] MODE_SHUTDOWN    = 4'd6;
    localparam logic [3:0] MODE_HV_ERROR    = 4'd7;
    localparam logic [3:0] MODE_FATAL       = 4'd8;

    localparam logic [2:0] BAT_RUNNING = 3'd1;
    localparam logic [2:0] BAT_LOW     = 3'd2;
    localparam logic [2:0] BAT_ERROR   = 3'd3;
    localparam logic [2:0] BAT_IDLE    = 3'd4;

    localparam logic [1:0] MOT_RUNNING   = 2'd1;
    localparam logic [1:0] MOT_START_ERR = 2'd2;
    localparam logic [1:0] MOT_RUN_ERR   = 2'd3;

    localparam logic [1:0] DASH_HV     = 2'd1;
    localparam logic [1:0] DASH_MOTORS = 2'd2;

    localparam int ADDR_BITS = 4;
    localparam logic [1:0] REG_STARTUP_DELAY    = 2'd0;
    localparam logic [1:0] REG_SPEAKER_DURATION = 2'd1;
    localparam logic [1:0] REG_TICK_PERIOD      = 2'd2;

    localparam logic [15:0] STARTUP_DELAY_RESET    = 16'd2000;
    localparam logic [15:0] SPEAKER_DURATION_RESET = 16'd2000;
    localparam logic [7:0]  TICK_PERIOD_RESET      = 8'd10;

    typedef struct packed {
        logic [15:0] startup_delay_ms;
        logic [15:0] speaker_duration_ms;
        logic [7:0]  tick_period_ms;
    } cfg_t;

endpackage

// ===== src/vehicle_power_up_sequencer.sv =====
// Top level of the vehicle power-up and shutdown sequencer.
// Instantiates vpus_apb_regs and vpus_core; depends on vpus_pkg.
//
// Each input beat is one periodic tick. The block accepts a new beat every
// cycle while the result channel is not stalled and returns one result beat
// per input beat, passing it through the input register and then the state
// update into the result register, which also decouples a stalled result channel.
// Configuration registers at byte addresses 0 (startup delay), 4 (speaker
// duration) and 8 (tick period) should be written only while the block is
// idle. The time-in-state counter is TIME_BITS wide and is reported
// saturated to 16 bits.
module vehicle_power_up_sequencer #(
    parameter int TIME_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vpus_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [2:0]                     s_battery_status,
    input  logic [1:0]                     s_motor_status,
    input  logic [1:0]                     s_dash_request,
    input  logic                           s_brake_pressed,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_battery_enable,
    output logic                           m_motor_enable,
    output logic [3:0]                     m_next_mode,
    output logic [15:0]                    m_time_in_mode_ms,
    output logic                           m_speaker_on
);
    import vpus_pkg::*;

    cfg_t cfg;

    vpus_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    vpus_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_i             (cfg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_battery_status  (s_battery_status),
        .s_motor_status    (s_motor_status),
        .s_dash_request    (s_dash_request),
        .s_brake_pressed   (s_brake_pressed),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_battery_enable  (m_battery_enable),
        .m_motor_enable    (m_motor_enable),
        .m_next_mode       (m_next_mode),
        .m_time_in_mode_ms (m_time_in_mode_ms),
        .m_speaker_on      (m_speaker_on)
    );

endmodule

// ===== src/vpus_apb_regs.sv =====
// APB configuration registers of the power-up sequencer.
// Depends on vpus_pkg for the register map and the configuration struct.
module vpus_apb_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vpus_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output vpus_pkg::cfg_t                 cfg_o
);
    import vpus_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg_o   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.startup_delay_ms    <= STARTUP_DELAY_RESET;
            cfg_reg.speaker_duration_ms <= SPEAKER_DURATION_RESET;
            cfg_reg.tick_period_ms      <= TICK_PERIOD_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_STARTUP_DELAY:    cfg_reg.startup_delay_ms    <= pwdata[15:0];
                REG_SPEAKER_DURATION: cfg_reg.speaker_duration_ms <= pwdata[15:0];
                REG_TICK_PERIOD:      cfg_reg.tick_period_ms      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STARTUP_DELAY:    prdata = {16'd0, cfg_reg.startup_delay_ms};
            REG_SPEAKER_DURATION: prdata = {16'd0, cfg_reg.speaker_duration_ms};
            REG_TICK_PERIOD:      prdata = {24'd0, cfg_reg.tick_period_ms};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

// ===== src/vpus_core.sv =====
// Sequencer core: input register, state update logic and result register.
// Depends on vpus_pkg for the state encoding, status codes and configuration struct.
module vpus_core #(
    parameter int TIME_BITS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  vpus_pkg::cfg_t cfg_i,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [2:0]     s_battery_status,
    input  logic [1:0]     s_motor_status,
    input  logic [1:0]     s_dash_request,
    input  logic           s_brake_pressed,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_battery_enable,
    output logic           m_motor_enable,
    output logic [3:0]     m_next_mode,
    output logic [15:0]    m_time_in_mode_ms,
    output logic           m_speaker_on
);
    import vpus_pkg::*;

    localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic       in_valid_reg;
    logic [2:0] bat_reg;
    logic [1:0] mot_reg;
    logic [1:0] dash_reg;
    logic       brake_reg;

    mode_t                mode_reg, mode_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic                 speaker_reg, speaker_next;

    logic        out_valid_reg, out_valid_next;
    logic        ben_reg, ben_next;
    logic        men_reg, men_next;
    logic [3:0]  code_reg, code_next;
    logic [15:0] tout_reg, tout_next;
    logic        spk_out_reg;

    logic                 step;
    logic                 load;
    logic [CW-1:0]        time_ext;
    logic [TIME_BITS-1:0] time_base;
    logic [TIME_BITS:0]   time_sum;
    logic [CW-1:0]        time_new_ext;

    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign load    = s_valid && s_ready;

    assign time_ext = CW'(time_reg);

    always_comb begin
        mode_next    = mode_reg;
        ben_next     = 1'b0;
        men_next     = 1'b0;
        speaker_next = speaker_reg;
        case (mode_reg)
            ST_INIT: begin
                if (time_ext >= CW'(cfg_i.startup_delay_ms) && dash_reg == DASH_HV) begin
                    mode_next = ST_HV_START;
                end
            end
            ST_HV_START: begin
                ben_next = 1'b1;
                if (bat_reg == BAT_RUNNING) begin
                    mode_next = ST_READY_WAIT;
                end
            end
            ST_READY_WAIT: begin
                ben_next = 1'b1;
                if (dash_reg == DASH_MOTORS) begin
                    mode_next = ST_MOTOR_START;
                end
            end
            ST_MOTOR_START: begin
                ben_next = 1'b1;
                men_next = 1'b1;
                if (mot_reg == MOT_RUNNING) begin
                    mode_next = ST_AWAIT_BRAKE;
                end else if (mot_reg == MOT_START_ERR) begin
                    mode_next = ST_FATAL;
                end
            end
            ST_AWAIT_BRAKE: begin
                ben_next = 1'b1;
                men_next = 1'b1;
                if (brake_reg) begin
                    mode_next = ST_RUNNING;
                end
            end
            ST_RUNNING: begin
                ben_next     = 1'b1;
                men_next     = 1'b1;
                speaker_next = time_ext < CW'(cfg_i.speaker_duration_ms);
                if (bat_reg == BAT_ERROR || mot_reg == MOT_RUN_ERR) begin
                    mode_next = ST_FATAL;
                end else if (bat_reg == BAT_LOW) begin
                    mode_next = ST_SHUTDOWN;
                end
            end
            ST_SHUTDOWN, ST_HV_ERROR: begin
                if (bat_reg == BAT_IDLE) begin
                    mode_next = ST_INIT;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        time_base = (mode_next != mode_reg) ? '0 : time_reg;
        time_sum  = {1'b0, time_base} + (TIME_BITS + 1)'(cfg_i.tick_period_ms);
        time_next = time_sum[TIME_BITS] ? TIME_MAX : time_sum[TIME_BITS-1:0];
        time_new_ext = CW'(time_next);
        tout_next = (time_new_ext > CW'(16'hFFFF)) ? 16'hFFFF : time_new_ext[15:0];
    end

    always_comb begin
        case (mode_next)
            ST_INIT:        code_next = MODE_INIT;
            ST_HV_START:    code_next = MODE_HV_START;
            ST_READY_WAIT:  code_next = MODE_READY_WAIT;
            ST_MOTOR_START: code_next = MODE_MOTOR_START;
            ST_AWAIT_BRAKE: code_next = MODE_AWAIT_BRAKE;
            ST_RUNNING:     code_next = MODE_RUNNING;
            ST_SHUTDOWN:    code_next = MODE_SHUTDOWN;
            ST_HV_ERROR:    code_next = MODE_HV_ERROR;
            default:        code_next = MODE_FATAL;
        endcase
    end

    always_comb begin
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= ST_INIT;
            time_reg      <= '0;
            speaker_reg   <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (load) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (step) begin
                mode_reg    <= mode_next;
                time_reg    <= time_next;
                speaker_reg <= speaker_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bat_reg   <= s_battery_status;
            mot_reg   <= s_motor_status;
            dash_reg  <= s_dash_request;
            brake_reg <= s_brake_pressed;
        end
        if (step) begin
            ben_reg     <= ben_next;
            men_reg     <= men_next;
            code_reg    <= code_next;
            tout_reg    <= tout_next;
            spk_out_reg <= speaker_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_battery_enable  = ben_reg;
    assign m_motor_enable    = men_reg;
    assign m_next_mode       = code_reg;
    assign m_time_in_mode_ms = tout_reg;
    assign m_speaker_on      = spk_out_reg;

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(mode_reg) && $stable(time_reg) && $stable(speaker_reg))
        else $error("Sequencer state changed without a step.");

    a_time_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && mode_next != mode_reg)
            |=> time_reg == TIME_BITS'($past(cfg_i.tick_period_ms)))
        else $error("Time in state did not restart on a state change.");

    a_speaker_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && mode_reg != ST_RUNNING) |=> $stable(speaker_reg))
        else $error("Speaker changed outside the running state.");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> out_valid_reg && !$stable(in_valid_reg) || in_valid_reg || out_valid_reg)
        else $error("A step did not produce a result beat.");

endmodule
